>>> rtl/core/ckvt_pkg.sv
// Shared types and constants for the compacting key/value table.
// Operation and status codes, controller states and the per-cell control beat.
// No dependencies.
`default_nettype none

package ckvt_pkg;

	localparam int KEY_W        = 7;
	localparam int VAL_W        = 4;
	localparam int OP_W         = 3;
	localparam int STATUS_W     = 3;
	localparam int POS_W        = 4;
	localparam int COUNT_W      = 5;
	localparam int CAPACITY_DEF = 16;
	localparam int RESULT_LIMIT = 16;
	localparam int HIT_W        = $clog2(RESULT_LIMIT + 1);

	localparam logic [KEY_W-1:0] KEY_MAX = 7'd99;
	localparam logic [VAL_W-1:0] VAL_MIN = 4'd1;
	localparam logic [VAL_W-1:0] VAL_MAX = 4'd9;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 3'd0,
		OP_DELETE   = 3'd1,
		OP_UPDATE   = 3'd2,
		OP_SEARCH   = 3'd3,
		OP_LIST_THR = 3'd4,
		OP_LIST_ALL = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_INVALID  = 3'd1,
		ST_DUP      = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic             rotate;
		logic             compact;
		logic             wr_en;
		logic             wr_key;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/ckvt_cell.sv
// One table slot of the ring: holds a key and a value.
// Takes its neighbor's entry on rotate, or on compact at or above the address, or an addressed write.
// Depends on ckvt_pkg.
`default_nettype none

module ckvt_cell
	import ckvt_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int IDX_W = 4
) (
	input  wire logic             clk,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic [IDX_W-1:0] addr,
	input  wire logic [KEY_W-1:0] nbr_key,
	input  wire logic [VAL_W-1:0] nbr_val,
	output logic      [KEY_W-1:0] cell_key,
	output logic      [VAL_W-1:0] cell_val
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (ctrl.rotate || (ctrl.compact && MY_IDX >= addr)) begin
			key_q <= nbr_key;
			val_q <= nbr_val;
		end else if (ctrl.wr_en && addr == MY_IDX) begin
			if (ctrl.wr_key) begin
				key_q <= ctrl.key;
			end
			val_q <= ctrl.val;
		end
	end

	assign cell_key = key_q;
	assign cell_val = val_q;

endmodule

`default_nettype wire

>>> rtl/core/compacting_key_value_table.sv
// Compacting key/value table: a ring of CAPACITY cells plus the operation controller.
// Depends on ckvt_pkg and ckvt_cell.
//
// Holds up to CAPACITY unique keys (0..99) with values (1..9) in insertion order.
// Every known operation rotates the ring of cells once around, examining each slot in
// turn at the head cell, then a closing step writes, compacts and issues the final
// result; rsp_stall can hold a listing beat or the final result back. Deletes close
// the gap by shifting later cells down in the closing step. Listings emit one beat
// per matching entry, at most RESULT_LIMIT, with last set on the final beat; an empty
// listing gives a single beat with the empty status. Operation codes 6 and 7 are taken
// and dropped without a result. req_stall is high while an operation is in work.
`default_nettype none

module compacting_key_value_table
	import ckvt_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic [OP_W-1:0]     operation,
	input  wire logic [KEY_W-1:0]    key,
	input  wire logic [VAL_W-1:0]    value,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic [STATUS_W-1:0]      status,
	output logic [POS_W-1:0]         position,
	output logic [KEY_W-1:0]         key_out,
	output logic [VAL_W-1:0]         value_out,
	output logic [COUNT_W-1:0]       entry_count_out,
	output logic                     last
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [HIT_W-1:0] HIT_MAX  = HIT_W'(RESULT_LIMIT);

	state_t           state_q, state_d;
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic             bad_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [HIT_W-1:0] hits_q;

	logic             pend_vld_q;
	logic [IDX_W-1:0] pend_pos_q;
	logic [KEY_W-1:0] pend_key_q;
	logic [VAL_W-1:0] pend_val_q;

	logic                rsp_vld_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]    pos_q;
	logic [KEY_W-1:0]    key_out_q;
	logic [VAL_W-1:0]    val_out_q;
	logic [COUNT_W-1:0]  cnt_out_q;
	logic                last_q;

	logic [KEY_W-1:0] ring_key [CAPACITY];
	logic [VAL_W-1:0] ring_val [CAPACITY];
	cell_ctrl_t       ctrl;
	logic [IDX_W-1:0] cell_addr;

	logic             req_beat, op_known, val_ok, bad_in;
	logic             out_free, is_list, in_range, cand, match, advance;
	logic             fire;
	status_t          fin_status;
	logic [IDX_W-1:0] fin_pos;
	logic [KEY_W-1:0] fin_key;
	logic [VAL_W-1:0] fin_val;
	logic [CNT_W-1:0] fin_cnt;
	logic             fin_write, fin_wr_key, fin_compact;

	// ring of cells, head at slot zero
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int NBR = (i + 1 == CAPACITY) ? 0 : i + 1;
		ckvt_cell #(
			.INDEX(i),
			.IDX_W(IDX_W)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.addr    (cell_addr),
			.nbr_key (ring_key[NBR]),
			.nbr_val (ring_val[NBR]),
			.cell_key(ring_key[i]),
			.cell_val(ring_val[i])
		);
	end

	assign req_stall = (state_q != S_IDLE);
	assign req_beat  = req_valid && !req_stall;
	assign op_known  = operation inside {OP_INSERT, OP_DELETE, OP_UPDATE, OP_SEARCH,
		OP_LIST_THR, OP_LIST_ALL};
	assign val_ok    = (value >= VAL_MIN) && (value <= VAL_MAX);

	always_comb begin
		case (op_t'(operation))
			OP_INSERT:   bad_in = (key > KEY_MAX) || !val_ok;
			OP_UPDATE:   bad_in = !val_ok;
			OP_LIST_THR: bad_in = !val_ok;
			default:     bad_in = 1'b0;
		endcase
	end

	assign out_free = !rsp_vld_q || !rsp_stall;
	assign is_list  = (op_q == OP_LIST_THR) || (op_q == OP_LIST_ALL);
	assign in_range = CNT_W'(idx_q) < cnt_q;
	assign cand     = (state_q == S_SCAN) && is_list && !bad_q && in_range &&
		((op_q == OP_LIST_ALL) || (ring_val[0] > val_q)) && (hits_q != HIT_MAX);
	assign match    = (state_q == S_SCAN) && !is_list && in_range &&
		(ring_key[0] == key_q) && !pend_vld_q;
	assign advance  = (state_q == S_SCAN) && !(cand && pend_vld_q && !out_free);
	assign fire     = (state_q == S_FINISH) && out_free;

	always_comb begin
		fin_status  = ST_OK;
		fin_pos     = pend_pos_q;
		fin_key     = pend_key_q;
		fin_val     = pend_val_q;
		fin_cnt     = cnt_q;
		fin_write   = 1'b0;
		fin_wr_key  = 1'b0;
		fin_compact = 1'b0;
		case (op_q)
			OP_INSERT: begin
				if (bad_q) begin
					fin_status = ST_INVALID;
				end else if (pend_vld_q) begin
					fin_status = ST_DUP;
				end else if (cnt_q >= CNT_FULL) begin
					fin_status = ST_FULL;
				end else begin
					fin_pos    = IDX_W'(cnt_q);
					fin_key    = key_q;
					fin_val    = val_q;
					fin_cnt    = CNT_W'(cnt_q + 1'b1);
					fin_write  = 1'b1;
					fin_wr_key = 1'b1;
				end
			end
			OP_DELETE: begin
				if (!pend_vld_q) begin
					fin_status = ST_NOTFOUND;
				end else begin
					fin_cnt     = CNT_W'(cnt_q - 1'b1);
					fin_compact = 1'b1;
				end
			end
			OP_UPDATE: begin
				if (bad_q) begin
					fin_status = ST_INVALID;
				end else if (!pend_vld_q) begin
					fin_status = ST_NOTFOUND;
				end else begin
					fin_val   = val_q;
					fin_write = 1'b1;
				end
			end
			OP_SEARCH: begin
				if (!pend_vld_q) begin
					fin_status = ST_NOTFOUND;
				end
			end
			OP_LIST_THR, OP_LIST_ALL: begin
				if (bad_q) begin
					fin_status = ST_INVALID;
				end else if (!pend_vld_q) begin
					fin_status = ST_EMPTY;
				end
			end
			default: fin_status = ST_OK;
		endcase
		if (fin_status != ST_OK && fin_status != ST_DUP) begin
			fin_pos = '0;
			fin_key = '0;
			fin_val = '0;
		end
	end

	always_comb begin
		ctrl.rotate  = advance;
		ctrl.compact = fire && fin_compact;
		ctrl.wr_en   = fire && fin_write;
		ctrl.wr_key  = fin_wr_key;
		ctrl.key     = key_q;
		ctrl.val     = val_q;
		cell_addr    = (op_q == OP_INSERT) ? IDX_W'(cnt_q) : pend_pos_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_beat && op_known) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (advance && idx_q == IDX_LAST) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (fire) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			idx_q      <= '0;
			hits_q     <= '0;
			pend_vld_q <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			if (fire || (advance && cand && pend_vld_q)) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
			if (req_beat) begin
				idx_q      <= '0;
				hits_q     <= '0;
				pend_vld_q <= 1'b0;
			end
			if (advance) begin
				idx_q <= idx_q + 1'b1;
				if (cand) begin
					hits_q     <= hits_q + 1'b1;
					pend_vld_q <= 1'b1;
				end
				if (match) begin
					pend_vld_q <= 1'b1;
				end
			end
			if (fire) begin
				cnt_q <= fin_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_beat) begin
			op_q  <= op_t'(operation);
			key_q <= key;
			val_q <= value;
			bad_q <= bad_in;
		end
		if (advance && (cand || match)) begin
			pend_pos_q <= idx_q;
			pend_key_q <= ring_key[0];
			pend_val_q <= ring_val[0];
		end
		if (advance && cand && pend_vld_q) begin
			status_q  <= ST_OK;
			pos_q     <= POS_W'(pend_pos_q);
			key_out_q <= pend_key_q;
			val_out_q <= pend_val_q;
			cnt_out_q <= COUNT_W'(cnt_q);
			last_q    <= 1'b0;
		end
		if (fire) begin
			status_q  <= fin_status;
			pos_q     <= POS_W'(fin_pos);
			key_out_q <= fin_key;
			val_out_q <= fin_val;
			cnt_out_q <= COUNT_W'(fin_cnt);
			last_q    <= 1'b1;
		end
	end

	assign rsp_valid       = rsp_vld_q;
	assign status          = status_q;
	assign position        = pos_q;
	assign key_out         = key_out_q;
	assign value_out       = val_out_q;
	assign entry_count_out = cnt_out_q;
	assign last            = last_q;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Testbench for compacting_key_value_table: directed table then random operations.
// Checks every result beat against a directed step's expected beat or a behavioral model.
// Depends on ckvt_pkg and the RTL of the table.
module tb_top;
	import ckvt_pkg::*;

	localparam int TABLE_SIZE   = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 390;
	localparam int DRAIN_CYCLES = 4 * (TABLE_SIZE + 2) + 64;
	localparam int TIMEOUT      = 15_000_000;

	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	typedef struct packed {
		status_t             status;
		logic [POS_W-1:0]    pos;
		logic [KEY_W-1:0]    key;
		logic [VAL_W-1:0]    val;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} table_beat_t;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
		bit               typed;
		table_beat_t      want;
	} table_step_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic [OP_W-1:0]      operation = '0;
	logic [KEY_W-1:0]     key = '0;
	logic [VAL_W-1:0]     value = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [POS_W-1:0]     position;
	logic [KEY_W-1:0]     key_out;
	logic [VAL_W-1:0]     value_out;
	logic [COUNT_W-1:0]   entry_count_out;
	logic                 last;

	logic [KEY_W-1:0]     held_key [TABLE_SIZE];
	logic [VAL_W-1:0]     held_val [TABLE_SIZE];
	int                   held = 0;

	table_beat_t          predicted_beats [$];
	table_beat_t          pending_beats [$];
	table_step_t          directed_steps [$];
	int                   error_count = 0;
	int                   hold_left = 0;
	bit                   calm = 1'b0;
	bit                   growing = 1'b1;

	compacting_key_value_table #(
		.CAPACITY(TABLE_SIZE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.operation(operation),
		.key(key),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.position(position),
		.key_out(key_out),
		.value_out(value_out),
		.entry_count_out(entry_count_out),
		.last(last)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void note_beat(status_t s, int p, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v, logic fin);
		table_beat_t b;
		b.status = s;
		b.pos    = p[POS_W-1:0];
		b.key    = k;
		b.val    = v;
		b.count  = held[COUNT_W-1:0];
		b.last   = fin;
		predicted_beats.push_back(b);
	endfunction

	function automatic void list_table(logic [VAL_W-1:0] thr, bit filter);
		int n;
		n = 0;
		for (int i = 0; i < held && n < RESULT_LIMIT; i++) begin
			if (!filter || held_val[i] > thr) begin
				note_beat(ST_OK, i, held_key[i], held_val[i], 1'b0);
				n++;
			end
		end
		if (n == 0)
			note_beat(ST_EMPTY, 0, '0, '0, 1'b1);
		else
			predicted_beats[predicted_beats.size() - 1].last = 1'b1;
	endfunction

	function automatic void predict_table_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		int idx;
		bit val_ok;
		logic [KEY_W-1:0] rk;
		logic [VAL_W-1:0] rv;
		predicted_beats.delete();
		val_ok = (v >= VAL_MIN) && (v <= VAL_MAX);
		idx = -1;
		for (int i = 0; i < held; i++)
			if (idx < 0 && held_key[i] == k)
				idx = i;
		case (op)
			OP_INSERT: begin
				if (k > KEY_MAX || !val_ok)
					note_beat(ST_INVALID, 0, '0, '0, 1'b1);
				else if (idx >= 0)
					note_beat(ST_DUP, idx, held_key[idx], held_val[idx], 1'b1);
				else if (held >= TABLE_SIZE)
					note_beat(ST_FULL, 0, '0, '0, 1'b1);
				else begin
					held_key[held] = k;
					held_val[held] = v;
					held++;
					note_beat(ST_OK, held - 1, k, v, 1'b1);
				end
			end
			OP_DELETE: begin
				if (idx < 0)
					note_beat(ST_NOTFOUND, 0, '0, '0, 1'b1);
				else begin
					rk = held_key[idx];
					rv = held_val[idx];
					for (int i = idx; i + 1 < held; i++) begin
						held_key[i] = held_key[i + 1];
						held_val[i] = held_val[i + 1];
					end
					held--;
					note_beat(ST_OK, idx, rk, rv, 1'b1);
				end
			end
			OP_UPDATE: begin
				if (!val_ok)
					note_beat(ST_INVALID, 0, '0, '0, 1'b1);
				else if (idx < 0)
					note_beat(ST_NOTFOUND, 0, '0, '0, 1'b1);
				else begin
					held_val[idx] = v;
					note_beat(ST_OK, idx, held_key[idx], v, 1'b1);
				end
			end
			OP_SEARCH: begin
				if (idx < 0)
					note_beat(ST_NOTFOUND, 0, '0, '0, 1'b1);
				else
					note_beat(ST_OK, idx, held_key[idx], held_val[idx], 1'b1);
			end
			OP_LIST_THR: begin
				if (!val_ok)
					note_beat(ST_INVALID, 0, '0, '0, 1'b1);
				else
					list_table(v, 1'b1);
			end
			OP_LIST_ALL: list_table('0, 1'b0);
			default: ;
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45 && held > 0)
			return held_key[$urandom_range(0, held - 1)];
		if (r < 80)
			return KEY_W'($urandom_range(0, 23));
		if (r < 93)
			return KEY_W'($urandom_range(0, 99));
		return KEY_W'($urandom_range(100, 127));
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 88)
			return VAL_W'($urandom_range(1, 9));
		return VAL_W'($urandom_range(0, 15));
	endfunction

	task automatic send_beat(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		key       <= k;
		value     <= v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic check_result_beat();
		table_beat_t got;
		table_beat_t want;
		got.status = status_t'(status);
		got.pos    = position;
		got.key    = key_out;
		got.val    = value_out;
		got.count  = entry_count_out;
		got.last   = last;
		if (pending_beats.size() == 0) begin
			if (error_count < 10)
				$display("unexpected result beat: status %0d pos %0d key %0d",
					got.status, got.pos, got.key,
					" value %0d count %0d last %0d", got.val, got.count, got.last);
			error_count++;
		end else begin
			want = pending_beats.pop_front();
			if (got !== want) begin
				if (error_count < 10) begin
					$display("result error: want status %0d pos %0d key %0d",
						want.status, want.pos, want.key,
						" value %0d count %0d last %0d", want.val, want.count, want.last);
					$display("              got  status %0d pos %0d key %0d",
						got.status, got.pos, got.key,
						" value %0d count %0d last %0d", got.val, got.count, got.last);
				end
				error_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				check_result_beat();
			if (hold_left != 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				hold_left = pick_gap();
				rsp_stall <= (hold_left != 0);
				if (hold_left != 0)
					hold_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic void add_step(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v, bit typed, status_t s, int p, logic [KEY_W-1:0] wk,
			logic [VAL_W-1:0] wv, int cnt);
		table_step_t t;
		t.op          = op;
		t.key         = k;
		t.val         = v;
		t.typed       = typed;
		t.want.status = s;
		t.want.pos    = p[POS_W-1:0];
		t.want.key    = wk;
		t.want.val    = wv;
		t.want.count  = cnt[COUNT_W-1:0];
		t.want.last   = 1'b1;
		directed_steps.push_back(t);
	endfunction

	initial begin
		int sent;
		int sel;
		int ins_cut;
		int del_cut;
		logic [OP_W-1:0] op;
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;

		add_step(OP_LIST_ALL, 7'd0,   4'd0,  1, ST_EMPTY,    0, 7'd0,  4'd0, 0);
		add_step(OP_SEARCH,   7'd5,   4'd3,  1, ST_NOTFOUND, 0, 7'd0,  4'd0, 0);
		add_step(OP_DELETE,   7'd5,   4'd3,  1, ST_NOTFOUND, 0, 7'd0,  4'd0, 0);
		add_step(OP_UPDATE,   7'd5,   4'd0,  1, ST_INVALID,  0, 7'd0,  4'd0, 0);
		add_step(OP_INSERT,   7'd127, 4'd5,  1, ST_INVALID,  0, 7'd0,  4'd0, 0);
		add_step(OP_INSERT,   7'd10,  4'd0,  1, ST_INVALID,  0, 7'd0,  4'd0, 0);
		add_step(OP_INSERT,   7'd10,  4'd15, 1, ST_INVALID,  0, 7'd0,  4'd0, 0);
		add_step(OP_INSERT,   7'd0,   4'd1,  1, ST_OK,       0, 7'd0,  4'd1, 1);
		add_step(OP_INSERT,   7'd99,  4'd9,  1, ST_OK,       1, 7'd99, 4'd9, 2);
		add_step(OP_INSERT,   7'd99,  4'd4,  1, ST_DUP,      1, 7'd99, 4'd9, 2);
		add_step(OP_INSERT,   7'd100, 4'd9,  1, ST_INVALID,  0, 7'd0,  4'd0, 2);
		add_step(OP_LIST_THR, 7'd0,   4'd0,  1, ST_INVALID,  0, 7'd0,  4'd0, 2);
		add_step(OP_LIST_THR, 7'd0,   4'd10, 1, ST_INVALID,  0, 7'd0,  4'd0, 2);
		add_step(OP_LIST_THR, 7'd0,   4'd9,  1, ST_EMPTY,    0, 7'd0,  4'd0, 2);
		add_step(OP_LIST_THR, 7'd0,   4'd8,  0, ST_OK,       0, 7'd0,  4'd0, 0);
		add_step(OP_SPARE_6,  7'd127, 4'd15, 0, ST_OK,       0, 7'd0,  4'd0, 0);
		add_step(OP_SPARE_7,  7'd0,   4'd0,  0, ST_OK,       0, 7'd0,  4'd0, 0);
		add_step(OP_UPDATE,   7'd99,  4'd1,  1, ST_OK,       1, 7'd99, 4'd1, 2);
		add_step(OP_UPDATE,   7'd50,  4'd3,  1, ST_NOTFOUND, 0, 7'd0,  4'd0, 2);
		add_step(OP_LIST_ALL, 7'd0,   4'd0,  0, ST_OK,       0, 7'd0,  4'd0, 0);
		add_step(OP_SEARCH,   7'd0,   4'd0,  1, ST_OK,       0, 7'd0,  4'd1, 2);
		add_step(OP_DELETE,   7'd0,   4'd0,  1, ST_OK,       0, 7'd0,  4'd1, 1);
		add_step(OP_SEARCH,   7'd99,  4'd0,  0, ST_OK,       0, 7'd0,  4'd0, 0);
		add_step(OP_INSERT,   7'd64,  4'd8,  0, ST_OK,       0, 7'd0,  4'd0, 0);
		add_step(OP_LIST_THR, 7'd0,   4'd1,  0, ST_OK,       0, 7'd0,  4'd0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			send_beat(directed_steps[i].op, directed_steps[i].key, directed_steps[i].val);
			predict_table_op(directed_steps[i].op, directed_steps[i].key,
				directed_steps[i].val);
			if (directed_steps[i].typed)
				pending_beats.push_back(directed_steps[i].want);
			else
				foreach (predicted_beats[j])
					pending_beats.push_back(predicted_beats[j]);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 40 == 0) begin
				growing = $urandom_range(0, 1);
				calm    = ($urandom_range(0, 3) == 0);
			end
			ins_cut = growing ? 50 : 18;
			del_cut = ins_cut + (growing ? 10 : 32);
			sel = $urandom_range(0, 99);
			k = pick_key();
			v = pick_value();
			if (sel < ins_cut)
				op = OP_INSERT;
			else if (sel < del_cut)
				op = OP_DELETE;
			else if (sel < del_cut + 10)
				op = OP_UPDATE;
			else if (sel < del_cut + 18)
				op = OP_SEARCH;
			else if (sel < del_cut + 28)
				op = OP_LIST_THR;
			else if (sel < del_cut + 36)
				op = OP_LIST_ALL;
			else begin
				op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
				k  = KEY_W'($urandom_range(0, 127));
				v  = VAL_W'($urandom_range(0, 15));
			end
			send_beat(op, k, v);
			predict_table_op(op, k, v);
			foreach (predicted_beats[j])
				pending_beats.push_back(predicted_beats[j]);
			if (op != OP_SPARE_6 && op != OP_SPARE_7)
				sent++;
		end

		req_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(TIMEOUT);
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/ckvt_pkg.sv
rtl/core/ckvt_cell.sv
rtl/core/compacting_key_value_table.sv
sim/tb_top.sv
